/* hdl/decimal_digit_stream_pattern_search_unit_macros.svh */
// assertion macros shared by the pattern search unit modules
// depends on nothing; included by each module that checks its own logic
`ifndef DECIMAL_DIGIT_STREAM_PATTERN_SEARCH_UNIT_MACROS_SVH
`define DECIMAL_DIGIT_STREAM_PATTERN_SEARCH_UNIT_MACROS_SVH

// same-cycle implication
`define DDSPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DDSPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/ddsps_pkg.sv */
// shared types and constants of the pattern search unit
// no dependencies; used by the interfaces and all modules
package ddsps_pkg;

   localparam int VALUE_W        = 31;
   localparam int OUT_W          = 32;
   localparam int DIGIT_W        = 4;
   localparam int NUM_DIGITS_MAX = 10;
   localparam int DIG_CNT_W      = $clog2(NUM_DIGITS_MAX + 1);
   localparam int DIG_IDX_W      = $clog2(NUM_DIGITS_MAX);
   localparam int RADIX          = 10;

   // divide by ten: q = (v * RECIP_10) >> RECIP_SHIFT, exact for v < 2^32
   localparam int RECIP_W        = 32;
   localparam logic [RECIP_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT    = 35;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_NUMBER  = 1'b0;
   localparam logic KIND_PATTERN = 1'b1;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [NUM_DIGITS_MAX-1:0][DIGIT_W-1:0] digits_type;

   // digits are least significant first
   typedef struct packed {
      logic                 kind;
      logic                 last;
      logic [DIG_CNT_W-1:0] count;
      digits_type           digits;
   } job_type;

endpackage

/* hdl/ddsps_req_if.sv */
// request channel of the pattern search unit: one number per beat
// depends on ddsps_pkg
interface ddsps_req_if;
   logic                          valid;
   logic                          ready;
   logic [ddsps_pkg::VALUE_W-1:0] number_value;
   logic                          last_number;

   modport source (output valid, output number_value, output last_number, input ready);
   modport sink   (input valid, input number_value, input last_number, output ready);
endinterface

/* hdl/ddsps_rsp_if.sv */
// response channel of the pattern search unit: one search result per beat
// depends on ddsps_pkg
interface ddsps_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ddsps_pkg::OUT_W-1:0] digit_total;
   logic                        found;
   logic [ddsps_pkg::OUT_W-1:0] match_position;

   modport source (output valid, output digit_total, output found, output match_position,
                   input ready);
   modport sink   (input valid, input digit_total, input found, input match_position,
                   output ready);
endinterface

/* hdl/decimal_digit_stream_pattern_search_unit.sv */
// Digit stream pattern search unit. Numbers arrive on req_bus as valid/ready
// beats; their decimal digits, most significant first, form one running stream.
// csr_wr_en/csr_wr_data load the pattern number; write it only while the unit
// is idle. The beat with last_number set closes the stream: one beat on rsp_bus
// carries the digit total, the found flag and the 1-based first match position.
// A front end splits each number with a divide-by-ten multiplier, one digit per
// cycle, and takes the next beat in the cycle its finished job enters the queue.
// A back end shifts one digit per cycle into the window and compares the pattern.
// The back end's one-digit-per-cycle window update, not the front end, sets the
// sustained beat rate; the queue lets the front take a new beat before the back
// end is through with the last one.
// Reset (synchronous) clears the stream and sets the pattern to zero, which
// matches at position 1. When rsp_bus stalls, the result is held in its output
// register; the queue and front end keep taking beats until the back end needs
// the output register for the next result.
module decimal_digit_stream_pattern_search_unit #(
   parameter int MAX_DIGITS  = 10,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   ddsps_req_if.sink                     req_bus,
   ddsps_rsp_if.source                   rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [ddsps_pkg::VALUE_W-1:0] csr_wr_data
);

   logic               push_valid;
   ddsps_pkg::job_type push_job;
   logic               q_full;
   logic               pop_valid;
   ddsps_pkg::job_type pop_job;
   logic               pop_en;

   ddsps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push_valid  (push_valid),
      .push_job    (push_job),
      .push_full   (q_full)
   );

   ddsps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (q_full),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_en     (pop_en)
   );

   ddsps_back #(
      .MAX_DIGITS  (MAX_DIGITS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_en    (pop_en),
      .rsp_bus   (rsp_bus)
   );

endmodule

/* hdl/ddsps_front.sv */
// front end: takes numbers and pattern writes and splits them into decimal digits
// depends on ddsps_pkg, ddsps_req_if and the assertion macro header
`include "decimal_digit_stream_pattern_search_unit_macros.svh"

module ddsps_front (
   input  logic                          clock,
   input  logic                          reset,
   ddsps_req_if.sink                     req_bus,
   input  logic                          csr_wr_en,
   input  logic [ddsps_pkg::VALUE_W-1:0] csr_wr_data,
   output logic                          push_valid,
   output ddsps_pkg::job_type            push_job,
   input  logic                          push_full
);

   localparam logic [1:0] FR_IDLE  = 2'd0;
   localparam logic [1:0] FR_SPLIT = 2'd1;
   localparam logic [1:0] FR_PUSH  = 2'd2;

   localparam int PROD_W = ddsps_pkg::VALUE_W + ddsps_pkg::RECIP_W;
   localparam int QUOT_W = PROD_W - ddsps_pkg::RECIP_SHIFT;

   logic [1:0]                      state_ff, state_in;
   logic [ddsps_pkg::VALUE_W-1:0]   work_ff, work_in;
   ddsps_pkg::job_type              job_ff, job_in;

   logic [PROD_W-1:0]               prod;
   logic [QUOT_W-1:0]               quot;
   ddsps_pkg::digit_type            rem;
   logic                            single_digit;
   logic                            accept;
   ddsps_pkg::job_type              load_job;

   assign prod  = work_ff * ddsps_pkg::RECIP_10;
   assign quot  = prod[PROD_W-1:ddsps_pkg::RECIP_SHIFT];
   // remainder fits in four bits, so only the low bits of v - 10q are needed
   assign rem   = work_ff[ddsps_pkg::DIGIT_W-1:0]
                  - ({quot[0], 3'b000} + {quot[2:0], 1'b0});
   assign single_digit = work_ff < ddsps_pkg::VALUE_W'(ddsps_pkg::RADIX);

   assign req_bus.ready = ((state_ff == FR_IDLE) || ((state_ff == FR_PUSH) && !push_full))
                          && !csr_wr_en;
   assign accept        = req_bus.valid && req_bus.ready;

   assign push_valid = (state_ff == FR_PUSH);
   assign push_job   = job_ff;

   always_comb begin
      load_job      = '0;
      load_job.kind = ddsps_pkg::KIND_NUMBER;
      load_job.last = req_bus.last_number;
   end

   always_comb begin
      state_in = state_ff;
      work_in  = work_ff;
      job_in   = job_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (csr_wr_en) begin
               work_in     = csr_wr_data;
               job_in      = '0;
               job_in.kind = ddsps_pkg::KIND_PATTERN;
               state_in    = FR_SPLIT;
            end else if (accept) begin
               work_in  = req_bus.number_value;
               job_in   = load_job;
               state_in = FR_SPLIT;
            end
         end
         FR_SPLIT: begin
            if (work_ff == '0) begin
               state_in = FR_PUSH;
            end else begin
               job_in.digits[job_ff.count[ddsps_pkg::DIG_IDX_W-1:0]] =
                  single_digit ? work_ff[ddsps_pkg::DIGIT_W-1:0] : rem;
               job_in.count = job_ff.count + 1'b1;
               if (single_digit) begin
                  state_in = FR_PUSH;
               end else begin
                  work_in = ddsps_pkg::VALUE_W'(quot);
               end
            end
         end
         FR_PUSH: begin
            if (!push_full) begin
               if (accept) begin
                  work_in  = req_bus.number_value;
                  job_in   = load_job;
                  state_in = FR_SPLIT;
               end else begin
                  state_in = FR_IDLE;
               end
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      job_ff  <= job_in;
   end

   `DDSPS_ASSERT_NOW(a_split_count, clock, reset, state_ff == FR_SPLIT, job_ff.count < ddsps_pkg::DIG_CNT_W'(ddsps_pkg::NUM_DIGITS_MAX), "front: digit count overflow")
   `DDSPS_ASSERT_NEXT(a_accept_split, clock, reset, accept, state_ff == FR_SPLIT, "front: beat taken but no split started")
   `DDSPS_ASSERT_NEXT(a_push_hold, clock, reset, (state_ff == FR_PUSH) && push_full, (state_ff == FR_PUSH) && $stable(job_ff), "front: job lost while queue full")

endmodule

/* hdl/ddsps_queue.sv */
// short job queue between the front and back ends
// depends on ddsps_pkg and the assertion macro header
`include "decimal_digit_stream_pattern_search_unit_macros.svh"

module ddsps_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  ddsps_pkg::job_type push_job,
   output logic               full,
   output logic               pop_valid,
   output ddsps_pkg::job_type pop_job,
   input  logic               pop_en
);

   ddsps_pkg::job_type              slot_ff [ddsps_pkg::QUEUE_DEPTH];
   logic [ddsps_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ddsps_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ddsps_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                            push_en;
   logic                            pop_do;

   assign full      = (count_ff == ddsps_pkg::QCNT_W'(ddsps_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = slot_ff[rd_ptr_ff];
   assign push_en   = push_valid && !full;
   assign pop_do    = pop_en && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_en) begin
         wr_ptr_in = (wr_ptr_ff == ddsps_pkg::QPTR_W'(ddsps_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_do) begin
         rd_ptr_in = (rd_ptr_ff == ddsps_pkg::QPTR_W'(ddsps_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_en, pop_do})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `DDSPS_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= ddsps_pkg::QCNT_W'(ddsps_pkg::QUEUE_DEPTH), "queue: count out of range")
   `DDSPS_ASSERT_NOW(a_full_ptrs, clock, reset, full, wr_ptr_ff == rd_ptr_ff, "queue: pointers disagree with full count")
   `DDSPS_ASSERT_NOW(a_pop_empty, clock, reset, count_ff == '0, !pop_en, "queue: pop while empty")

endmodule

/* hdl/ddsps_back.sv */
// back end: pushes digits into the stream window, matches the pattern, builds results
// depends on ddsps_pkg, ddsps_rsp_if and the assertion macro header
`include "decimal_digit_stream_pattern_search_unit_macros.svh"

module ddsps_back #(
   parameter int MAX_DIGITS  = 10,
   parameter int COUNT_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  ddsps_pkg::job_type pop_job,
   output logic               pop_en,
   ddsps_rsp_if.source        rsp_bus
);

   localparam logic BK_IDLE = 1'b0;
   localparam logic BK_RUN  = 1'b1;

   localparam int FILL_W = $clog2(MAX_DIGITS + 1);
   localparam int WIDE_W = COUNT_WIDTH + ddsps_pkg::OUT_W;

   logic                                   state_ff, state_in;
   ddsps_pkg::job_type                     job_ff, job_in;
   logic [ddsps_pkg::DIG_CNT_W-1:0]        left_ff, left_in;
   logic [MAX_DIGITS-1:0][ddsps_pkg::DIGIT_W-1:0] win_ff, win_in;
   logic [FILL_W-1:0]                      fill_ff, fill_in;
   logic [COUNT_WIDTH-1:0]                 count_ff, count_in;
   logic                                   seen_ff, seen_in;
   logic [COUNT_WIDTH-1:0]                 first_ff, first_in;
   ddsps_pkg::digits_type                  pat_ff, pat_in;
   logic [ddsps_pkg::DIG_CNT_W-1:0]        plen_ff, plen_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [ddsps_pkg::OUT_W-1:0]            total_ff, total_in;
   logic                                   found_ff, found_in;
   logic [ddsps_pkg::OUT_W-1:0]            pos_ff, pos_in;

   logic [ddsps_pkg::DIG_IDX_W-1:0]        rd_idx;
   ddsps_pkg::digit_type                   cur_digit;
   ddsps_pkg::digits_type                  lane;
   logic [ddsps_pkg::NUM_DIGITS_MAX-1:0]   cmp_ok;
   logic                                   step;
   logic                                   done;
   logic                                   out_free;
   logic                                   emit;
   logic                                   hit;
   logic [FILL_W-1:0]                      fill_new;
   logic [COUNT_WIDTH-1:0]                 count_new;
   logic [WIDE_W-1:0]                      total_wide;
   logic [WIDE_W-1:0]                      first_wide;
   logic [ddsps_pkg::OUT_W-1:0]            total_sat;
   logic [ddsps_pkg::OUT_W-1:0]            first_sat;

   assign pop_en    = (state_ff == BK_IDLE) && pop_valid;
   assign rd_idx    = left_ff[ddsps_pkg::DIG_IDX_W-1:0] - 1'b1;
   assign cur_digit = job_ff.digits[rd_idx];
   assign step      = (state_ff == BK_RUN) && (left_ff != '0);
   assign done      = (state_ff == BK_RUN) && (left_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign emit      = done && job_ff.last && out_free;

   assign fill_new  = (fill_ff == FILL_W'(MAX_DIGITS)) ? fill_ff : fill_ff + 1'b1;
   assign count_new = (count_ff == '1) ? count_ff : count_ff + 1'b1;

   // newest digit in lane 0, older ones behind it
   always_comb begin
      lane[0] = cur_digit;
      for (int k = 1; k < ddsps_pkg::NUM_DIGITS_MAX; k++) begin
         lane[k] = win_ff[k-1];
      end
      for (int k = 0; k < ddsps_pkg::NUM_DIGITS_MAX; k++) begin
         cmp_ok[k] = (ddsps_pkg::DIG_CNT_W'(k) >= plen_ff) || (lane[k] == pat_ff[k]);
      end
   end

   assign hit = step && !seen_ff && (plen_ff != '0)
                && (fill_new >= FILL_W'(plen_ff)) && (&cmp_ok);

   assign total_wide = WIDE_W'(count_ff);
   assign first_wide = WIDE_W'(first_ff);
   assign total_sat  = (total_wide[WIDE_W-1:ddsps_pkg::OUT_W] != '0)
                       ? '1 : total_wide[ddsps_pkg::OUT_W-1:0];
   assign first_sat  = (first_wide[WIDE_W-1:ddsps_pkg::OUT_W] != '0)
                       ? '1 : first_wide[ddsps_pkg::OUT_W-1:0];

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      left_in      = left_ff;
      win_in       = win_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      seen_in      = seen_ff;
      first_in     = first_ff;
      pat_in       = pat_ff;
      plen_in      = plen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      total_in     = total_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               if (pop_job.kind == ddsps_pkg::KIND_PATTERN) begin
                  pat_in  = pop_job.digits;
                  plen_in = pop_job.count;
               end else begin
                  job_in   = pop_job;
                  left_in  = pop_job.count;
                  state_in = BK_RUN;
               end
            end
         end
         BK_RUN: begin
            if (step) begin
               left_in   = left_ff - 1'b1;
               win_in[0] = cur_digit;
               for (int i = 1; i < MAX_DIGITS; i++) begin
                  win_in[i] = win_ff[i-1];
               end
               fill_in  = fill_new;
               count_in = count_new;
               if (hit) begin
                  seen_in  = 1'b1;
                  first_in = count_new - COUNT_WIDTH'(plen_ff) + 1'b1;
               end
            end else if (!job_ff.last) begin
               state_in = BK_IDLE;
            end else if (emit) begin
               rsp_valid_in = 1'b1;
               total_in     = total_sat;
               if (plen_ff == '0) begin
                  found_in = 1'b1;
                  pos_in   = ddsps_pkg::OUT_W'(1);
               end else if (seen_ff) begin
                  found_in = 1'b1;
                  pos_in   = first_sat;
               end else begin
                  found_in = 1'b0;
                  pos_in   = '0;
               end
               fill_in  = '0;
               count_in = '0;
               seen_in  = 1'b0;
               first_in = '0;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         first_ff     <= '0;
         plen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         first_ff     <= first_in;
         plen_ff      <= plen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      left_ff  <= left_in;
      win_ff   <= win_in;
      pat_ff   <= pat_in;
      total_ff <= total_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.digit_total    = total_ff;
   assign rsp_bus.found          = found_ff;
   assign rsp_bus.match_position = pos_ff;

   `DDSPS_ASSERT_NOW(a_seen_pos, clock, reset, seen_ff, first_ff != '0, "back: match recorded at position zero")
   `DDSPS_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid_ff && !found_ff, pos_ff == '0, "back: position set without a match")
   `DDSPS_ASSERT_NOW(a_left_range, clock, reset, state_ff == BK_RUN, left_ff <= ddsps_pkg::DIG_CNT_W'(ddsps_pkg::NUM_DIGITS_MAX), "back: digit count out of range")
   `DDSPS_ASSERT_NOW(a_fill_range, clock, reset, 1'b1, fill_ff <= FILL_W'(MAX_DIGITS), "back: window fill out of range")

endmodule
